FILE: rtl/core/assert_macros.svh
// Assertion helpers for the click classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/bclc_pkg.sv
package bclc_pkg;

   typedef logic [2:0]  key_event_type;
   typedef logic [1:0]  phase_type;
   typedef logic [15:0] hold_type;
   typedef logic [7:0]  gap_type;
   typedef logic [1:0]  csr_index_type;
   typedef logic [15:0] csr_data_type;

   localparam key_event_type EV_NONE   = 3'd0;
   localparam key_event_type EV_CLICK  = 3'd1;
   localparam key_event_type EV_DOUBLE = 3'd2;
   localparam key_event_type EV_LONG   = 3'd3;
   localparam key_event_type EV_VLONG  = 3'd4;

   localparam phase_type PH_IDLE    = 2'd0;
   localparam phase_type PH_CONFIRM = 2'd1;
   localparam phase_type PH_TIMING  = 2'd2;
   localparam phase_type PH_WAIT    = 2'd3;

   localparam csr_index_type CSR_LONG_TICKS      = 2'd0;
   localparam csr_index_type CSR_VERY_LONG_TICKS = 2'd1;
   localparam csr_index_type CSR_WINDOW_TICKS    = 2'd2;

   localparam hold_type RST_LONG_TICKS      = 16'd200;
   localparam hold_type RST_VERY_LONG_TICKS = 16'd500;
   localparam gap_type  RST_WINDOW_TICKS    = 8'd50;

   localparam hold_type HOLD_MAX = 16'hFFFF;

endpackage

FILE: rtl/core/bclc_req_if.sv
interface bclc_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink (input valid, input pin_level, output ready);
endinterface

FILE: rtl/core/bclc_rsp_if.sv
interface bclc_rsp_if import bclc_pkg::*;;
   logic          valid;
   logic          ready;
   key_event_type key_event;

   modport source (output valid, output key_event, input ready);
   modport sink (input valid, input key_event, output ready);
endinterface

FILE: rtl/core/button_click_long_double_classifier_top.sv
// channel   | dir | payload              | handshake
// req_chan  | in  | pin_level   (1 bit)  | valid / ready
// rsp_chan  | out | key_event   (3 bit)  | valid / ready
// csr_*     | in  | index 2 bit, data 16 | write enable, no wait
//
// One item in, one item out; the event is registered, 1 item per cycle sustained while rsp_chan is ready.
// The state update runs in the accept cycle and the event lands in the
// output register. req_chan.ready is high out of reset while that register
// is empty or being drained, so a stall on rsp_chan holds at most one item.
// Reset is synchronous and restores the register defaults and idle state.
`include "assert_macros.svh"

module button_click_long_double_classifier_top import bclc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   bclc_req_if.sink      req_chan,
   bclc_rsp_if.source    rsp_chan,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wdata
);

   hold_type      long_ticks_ff, very_long_ticks_ff;
   gap_type       window_ff;
   phase_type     phase_ff, phase_in;
   hold_type      hold_count_ff, hold_count_in;
   logic          click_pending_ff, click_pending_in;
   gap_type       gap_count_ff, gap_count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   key_event_type key_event_ff, key_event_in;

   logic          req_accept;
   logic          pin;
   hold_type      hold_inc;
   key_event_type press_ev;
   gap_type       gap_inc;

   assign req_chan.ready     = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept         = req_chan.valid && req_chan.ready;
   assign pin                = req_chan.pin_level;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.key_event = key_event_ff;

   assign hold_inc = (hold_count_ff == HOLD_MAX) ? hold_count_ff : hold_count_ff + 16'd1;
   assign gap_inc  = gap_count_ff + 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      hold_count_in = hold_count_ff;
      press_ev      = EV_NONE;
      case (phase_ff)
         PH_IDLE: begin
            if (!pin) phase_in = PH_CONFIRM;
         end
         PH_CONFIRM: begin
            if (!pin) begin
               hold_count_in = '0;
               phase_in      = PH_TIMING;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_TIMING: begin
            if (pin) begin
               press_ev = EV_CLICK;
               phase_in = PH_IDLE;
            end
            hold_count_in = hold_inc;
            // threshold test follows the release test
            if (hold_inc >= long_ticks_ff || hold_inc >= very_long_ticks_ff)
               phase_in = PH_WAIT;
         end
         default: begin
            if (pin) begin
               if (hold_count_ff >= very_long_ticks_ff)  press_ev = EV_VLONG;
               else if (hold_count_ff >= long_ticks_ff) press_ev = EV_LONG;
               phase_in = PH_IDLE;
            end else begin
               hold_count_in = hold_inc;
            end
         end
      endcase
   end

   always_comb begin
      click_pending_in = click_pending_ff;
      gap_count_in     = gap_count_ff;
      key_event_in     = EV_NONE;
      if (!click_pending_ff) begin
         if (press_ev == EV_CLICK) begin
            gap_count_in     = '0;
            click_pending_in = 1'b1;
         end else begin
            key_event_in = press_ev;
         end
      end else if (press_ev == EV_CLICK) begin
         key_event_in     = EV_DOUBLE;
         click_pending_in = 1'b0;
      end else begin
         gap_count_in = gap_inc;
         if (gap_inc >= window_ff) begin
            key_event_in     = EV_CLICK;
            click_pending_in = 1'b0;
         end
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff      <= RST_LONG_TICKS;
         very_long_ticks_ff <= RST_VERY_LONG_TICKS;
         window_ff          <= RST_WINDOW_TICKS;
         phase_ff           <= PH_IDLE;
         hold_count_ff      <= '0;
         click_pending_ff   <= 1'b0;
         gap_count_ff       <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LONG_TICKS:      long_ticks_ff      <= csr_wdata;
               CSR_VERY_LONG_TICKS: very_long_ticks_ff <= csr_wdata;
               CSR_WINDOW_TICKS:    window_ff          <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_accept) begin
            phase_ff         <= phase_in;
            hold_count_ff    <= hold_count_in;
            click_pending_ff <= click_pending_in;
            gap_count_ff     <= gap_count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) key_event_ff <= key_event_in;
   end

   `ASSERT_NEXT(a_accept_fills_out, clock, reset, req_accept, rsp_valid_ff)
   `ASSERT_NEXT(a_pending_kept, clock, reset,
      req_accept && click_pending_ff && key_event_in == EV_NONE, click_pending_ff)
   `ASSERT_NEXT(a_confirm_starts_timing, clock, reset,
      req_accept && phase_ff == PH_CONFIRM && !pin,
      phase_ff == PH_TIMING && hold_count_ff == '0)
   `ASSERT_IMPLIES(a_pending_masks_long, clock, reset, req_accept && click_pending_ff,
      key_event_in == EV_NONE || key_event_in == EV_CLICK || key_event_in == EV_DOUBLE)

endmodule
